[sv/ctc_pkg.sv]
// Shared types and constants for the colour threshold and centroid core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

  // Default values of the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Fixed field and accumulator widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned LW_W     = 12;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned PASS_W   = 23;
  localparam int unsigned SUM_W    = 43;
  localparam int unsigned WGT_W    = 32;
  localparam int unsigned CENT_W   = 19;

  // Weight of a passing pixel when the mask is the weight source (3 * 255)
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 10'd765;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;

  // APB port geometry
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Result kinds
  localparam logic KIND_MASK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Weight source codes
  localparam logic WSRC_RGB  = 1'b0;
  localparam logic WSRC_MASK = 1'b1;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_RED_LOW     = 3'd0,
    REG_RED_HIGH    = 3'd1,
    REG_GREEN_LOW   = 3'd2,
    REG_GREEN_HIGH  = 3'd3,
    REG_BLUE_LOW    = 3'd4,
    REG_BLUE_HIGH   = 3'd5,
    REG_LINE_WIDTH  = 3'd6,
    REG_WEIGHT_SRC  = 3'd7
  } reg_idx_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_MASK,
    ST_CHECK,
    ST_DIV,
    ST_LOAD
  } back_state_t;

  // One input pixel
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic              mask_on;
    logic [PASS_W-1:0] pass_count;
    logic [CENT_W-1:0] centroid_x;
    logic [CENT_W-1:0] centroid_y;
    logic              cog_valid;
    logic              last;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic [PIX_W-1:0] red_low;
    logic [PIX_W-1:0] red_high;
    logic [PIX_W-1:0] green_low;
    logic [PIX_W-1:0] green_high;
    logic [PIX_W-1:0] blue_low;
    logic [PIX_W-1:0] blue_high;
    logic [LW_W-1:0]  line_width;
    logic             weight_source;
  } cfg_t;

  // Frame totals handed from front to back at the end of a frame
  typedef struct packed {
    logic [PASS_W-1:0] passed;
    logic [SUM_W-1:0]  sum_x;
    logic [SUM_W-1:0]  sum_y;
    logic [WGT_W-1:0]  total;
  } snap_t;

  // Queue entry: one classified pixel
  typedef struct packed {
    logic frame_end;
    logic mask_on;
  } qent_t;

endpackage

`default_nettype wire

[sv/ctc_cfg.sv]
// APB register file holding the thresholds, line width and weight source.
// Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ctc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ctc_pkg::APB_DW-1:0]  pwdata,
  output logic      [ctc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output ctc_pkg::cfg_t                    cfg_regs
);

  ctc_pkg::cfg_t     regs_r;
  ctc_pkg::cfg_t     regs_nxt;
  ctc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = ctc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Register write decode
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        ctc_pkg::REG_RED_LOW:    regs_nxt.red_low       = pwdata[ctc_pkg::PIX_W-1:0];
        ctc_pkg::REG_RED_HIGH:   regs_nxt.red_high      = pwdata[ctc_pkg::PIX_W-1:0];
        ctc_pkg::REG_GREEN_LOW:  regs_nxt.green_low     = pwdata[ctc_pkg::PIX_W-1:0];
        ctc_pkg::REG_GREEN_HIGH: regs_nxt.green_high    = pwdata[ctc_pkg::PIX_W-1:0];
        ctc_pkg::REG_BLUE_LOW:   regs_nxt.blue_low      = pwdata[ctc_pkg::PIX_W-1:0];
        ctc_pkg::REG_BLUE_HIGH:  regs_nxt.blue_high     = pwdata[ctc_pkg::PIX_W-1:0];
        ctc_pkg::REG_LINE_WIDTH: regs_nxt.line_width    = pwdata[ctc_pkg::LW_W-1:0];
        ctc_pkg::REG_WEIGHT_SRC: regs_nxt.weight_source = pwdata[0];
        default: ;
      endcase
    end
  end

  // Register storage with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.red_low       <= '0;
      regs_r.red_high      <= '1;
      regs_r.green_low     <= '0;
      regs_r.green_high    <= '1;
      regs_r.blue_low      <= '0;
      regs_r.blue_high     <= '1;
      regs_r.line_width    <= 12'd640;
      regs_r.weight_source <= ctc_pkg::WSRC_RGB;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      ctc_pkg::REG_RED_LOW:    prdata = ctc_pkg::APB_DW'(regs_r.red_low);
      ctc_pkg::REG_RED_HIGH:   prdata = ctc_pkg::APB_DW'(regs_r.red_high);
      ctc_pkg::REG_GREEN_LOW:  prdata = ctc_pkg::APB_DW'(regs_r.green_low);
      ctc_pkg::REG_GREEN_HIGH: prdata = ctc_pkg::APB_DW'(regs_r.green_high);
      ctc_pkg::REG_BLUE_LOW:   prdata = ctc_pkg::APB_DW'(regs_r.blue_low);
      ctc_pkg::REG_BLUE_HIGH:  prdata = ctc_pkg::APB_DW'(regs_r.blue_high);
      ctc_pkg::REG_LINE_WIDTH: prdata = ctc_pkg::APB_DW'(regs_r.line_width);
      ctc_pkg::REG_WEIGHT_SRC: prdata = ctc_pkg::APB_DW'(regs_r.weight_source);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_regs = regs_r;

endmodule

`default_nettype wire

[sv/ctc_front.sv]
// Front end: accepts pixels, applies the thresholds, keeps the position and
// weighted sums, and hands frame totals to the back end. Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_front #(
  parameter int unsigned MAX_WIDTH  = ctc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ctc_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ctc_pkg::in_item_t in_data,
  input  wire ctc_pkg::cfg_t     cfg_regs,
  input  wire logic              q_full,
  output logic                   q_push,
  output ctc_pkg::qent_t         q_data,
  input  wire logic              snap_done,
  output logic                   snap_busy,
  output ctc_pkg::snap_t         snap
);

  localparam int unsigned COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned MH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CMP_A = (MW_W > MH_W) ? MW_W : MH_W;
  localparam int unsigned CMP_W = ((CMP_A > ctc_pkg::LW_W) ? CMP_A : ctc_pkg::LW_W) + 1;
  localparam int unsigned PX_W  = ctc_pkg::WEIGHT_W + COL_W;
  localparam int unsigned PY_W  = ctc_pkg::WEIGHT_W + ROW_W;

  logic [COL_W-1:0]           column_r, column_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [ctc_pkg::PASS_W-1:0] passed_r, passed_nxt;
  logic [ctc_pkg::SUM_W-1:0]  sum_x_r, sum_x_nxt;
  logic [ctc_pkg::SUM_W-1:0]  sum_y_r, sum_y_nxt;
  logic [ctc_pkg::WGT_W-1:0]  total_r, total_nxt;
  ctc_pkg::snap_t             snap_r, snap_nxt;
  logic                       snap_busy_r, snap_busy_nxt;

  logic                         accept;
  logic                         pass;
  logic [ctc_pkg::WEIGHT_W-1:0] weight;
  logic [PX_W-1:0]              prod_x;
  logic [PY_W-1:0]              prod_y;
  logic [ctc_pkg::PASS_W:0]     pass_add;
  logic [ctc_pkg::SUM_W:0]      sx_add, sy_add;
  logic [ctc_pkg::WGT_W:0]      tw_add;
  logic [ctc_pkg::PASS_W-1:0]   passed_upd;
  logic [ctc_pkg::SUM_W-1:0]    sum_x_upd, sum_y_upd;
  logic [ctc_pkg::WGT_W-1:0]    total_upd;
  logic [CMP_W-1:0]             width_eff, col_inc, row_inc;

  // Handshake: stall on a full queue, or on a frame end while totals are in use
  assign in_stall = q_full || (in_data.frame_end && snap_busy_r);
  assign accept   = in_valid && !in_stall;

  // Threshold test and pixel weight
  assign pass = (in_data.red   >= cfg_regs.red_low)   && (in_data.red   <= cfg_regs.red_high)   &&
                (in_data.green >= cfg_regs.green_low) && (in_data.green <= cfg_regs.green_high) &&
                (in_data.blue  >= cfg_regs.blue_low)  && (in_data.blue  <= cfg_regs.blue_high);

  always_comb begin
    if (cfg_regs.weight_source == ctc_pkg::WSRC_MASK) begin
      weight = pass ? ctc_pkg::FULL_WEIGHT : '0;
    end else begin
      weight = ctc_pkg::WEIGHT_W'(in_data.red) + ctc_pkg::WEIGHT_W'(in_data.green) +
               ctc_pkg::WEIGHT_W'(in_data.blue);
    end
  end

  // Weighted position terms
  assign prod_x = PX_W'(weight) * PX_W'(column_r);
  assign prod_y = PY_W'(weight) * PY_W'(row_r);

  // Saturating accumulators
  assign pass_add   = {1'b0, passed_r} + (ctc_pkg::PASS_W + 1)'(pass);
  assign sx_add     = {1'b0, sum_x_r} + (ctc_pkg::SUM_W + 1)'(prod_x);
  assign sy_add     = {1'b0, sum_y_r} + (ctc_pkg::SUM_W + 1)'(prod_y);
  assign tw_add     = {1'b0, total_r} + (ctc_pkg::WGT_W + 1)'(weight);
  assign passed_upd = pass_add[ctc_pkg::PASS_W] ? '1 : pass_add[ctc_pkg::PASS_W-1:0];
  assign sum_x_upd  = sx_add[ctc_pkg::SUM_W]    ? '1 : sx_add[ctc_pkg::SUM_W-1:0];
  assign sum_y_upd  = sy_add[ctc_pkg::SUM_W]    ? '1 : sy_add[ctc_pkg::SUM_W-1:0];
  assign total_upd  = tw_add[ctc_pkg::WGT_W]    ? '1 : tw_add[ctc_pkg::WGT_W-1:0];

  // Effective line width, clamped to one and to the largest supported width
  always_comb begin
    width_eff = CMP_W'(cfg_regs.line_width);
    if (width_eff == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_eff > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end
  end

  assign col_inc = CMP_W'(column_r) + CMP_W'(1);
  assign row_inc = CMP_W'(row_r) + CMP_W'(1);

  // Next state of position, sums and the frame totals handed to the back end
  always_comb begin
    column_nxt    = column_r;
    row_nxt       = row_r;
    passed_nxt    = passed_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    total_nxt     = total_r;
    snap_nxt      = snap_r;
    snap_busy_nxt = snap_busy_r;
    if (snap_done) begin
      snap_busy_nxt = 1'b0;
    end
    if (accept) begin
      if (in_data.frame_end) begin
        snap_nxt.passed = passed_upd;
        snap_nxt.sum_x  = sum_x_upd;
        snap_nxt.sum_y  = sum_y_upd;
        snap_nxt.total  = total_upd;
        snap_busy_nxt   = 1'b1;
        column_nxt      = '0;
        row_nxt         = '0;
        passed_nxt      = '0;
        sum_x_nxt       = '0;
        sum_y_nxt       = '0;
        total_nxt       = '0;
      end else begin
        passed_nxt = passed_upd;
        sum_x_nxt  = sum_x_upd;
        sum_y_nxt  = sum_y_upd;
        total_nxt  = total_upd;
        if (col_inc >= width_eff) begin
          column_nxt = '0;
          if (row_inc < CMP_W'(MAX_HEIGHT)) begin
            row_nxt = row_inc[ROW_W-1:0];
          end
        end else begin
          column_nxt = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      row_r       <= '0;
      passed_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      total_r     <= '0;
      snap_busy_r <= 1'b0;
    end else begin
      column_r    <= column_nxt;
      row_r       <= row_nxt;
      passed_r    <= passed_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      total_r     <= total_nxt;
      snap_busy_r <= snap_busy_nxt;
    end
  end

  // Frame totals are payload only
  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign q_push            = accept;
  assign q_data.frame_end  = in_data.frame_end;
  assign q_data.mask_on    = pass;
  assign snap_busy         = snap_busy_r;
  assign snap              = snap_r;

endmodule

`default_nettype wire

[sv/ctc_queue.sv]
// Short first-in first-out queue of classified pixels between front and back.
// Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ctc_pkg::qent_t push_data,
  output logic                full,
  input  wire logic           pop,
  output ctc_pkg::qent_t      pop_data,
  output logic                empty
);

  localparam int unsigned AW = $clog2(ctc_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(ctc_pkg::QDEPTH + 1);

  ctc_pkg::qent_t entries_r [ctc_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(ctc_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  // Pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(ctc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(ctc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // Fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ctc_pkg::QDEPTH))
    else $error("queue fill level beyond depth");

  // No read from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  // No write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");

endmodule

`default_nettype wire

[sv/ctc_back.sv]
// Back end: turns queued pixels into mask results and, at a frame end, runs
// the restoring divider for the centroid and issues the summary. Depends on ctc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctc_back #(
  parameter int unsigned FRAC_BITS = ctc_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire ctc_pkg::qent_t  q_data,
  output logic                 q_pop,
  input  wire ctc_pkg::snap_t  snap,
  input  wire logic            snap_busy,
  output logic                 snap_done,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ctc_pkg::out_item_t   out_data
);

  localparam int unsigned QW    = ctc_pkg::CENT_W;
  localparam int unsigned WW    = ctc_pkg::WGT_W;
  localparam int unsigned DW    = ctc_pkg::SUM_W + FRAC_BITS;
  localparam int unsigned CMPW  = (DW > WW + QW) ? DW : WW + QW;
  localparam int unsigned CNT_W = $clog2(QW);

  ctc_pkg::back_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ctc_pkg::out_item_t   out_data_r, out_data_nxt;
  logic [WW-1:0]        rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [QW-1:0]        dlo_x_r, dlo_x_nxt, dlo_y_r, dlo_y_nxt;
  logic [QW-1:0]        quo_x_r, quo_x_nxt, quo_y_r, quo_y_nxt;
  logic                 sat_x_r, sat_x_nxt, sat_y_r, sat_y_nxt;
  logic                 zero_r, zero_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic            out_free;
  logic [CMPW-1:0] dvd_x, dvd_y, lim;
  logic [WW:0]     sh_x, sh_y, dvs;
  logic            ge_x, ge_y;
  logic [QW-1:0]   cent_x, cent_y;

  assign out_free = !out_valid_r || !out_stall;

  // Scaled dividends and the saturation limit (total times two to the quotient width)
  assign dvd_x = CMPW'(snap.sum_x) << FRAC_BITS;
  assign dvd_y = CMPW'(snap.sum_y) << FRAC_BITS;
  assign lim   = CMPW'(snap.total) << QW;

  // One restoring division step per cycle on each axis
  assign dvs  = {1'b0, snap.total};
  assign sh_x = {rem_x_r, dlo_x_r[QW-1]};
  assign sh_y = {rem_y_r, dlo_y_r[QW-1]};
  assign ge_x = (sh_x >= dvs);
  assign ge_y = (sh_y >= dvs);

  // Final centroid values with saturation and the zero-weight case
  assign cent_x = zero_r ? '0 : (sat_x_r ? '1 : quo_x_r);
  assign cent_y = zero_r ? '0 : (sat_y_r ? '1 : quo_y_r);

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rem_x_nxt     = rem_x_r;
    rem_y_nxt     = rem_y_r;
    dlo_x_nxt     = dlo_x_r;
    dlo_y_nxt     = dlo_y_r;
    quo_x_nxt     = quo_x_r;
    quo_y_nxt     = quo_y_r;
    sat_x_nxt     = sat_x_r;
    sat_y_nxt     = sat_y_r;
    zero_nxt      = zero_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    snap_done     = 1'b0;
    case (state_r)
      ctc_pkg::ST_MASK: begin
        if (!q_empty && out_free) begin
          q_pop                   = 1'b1;
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.kind       = ctc_pkg::KIND_MASK;
          out_data_nxt.mask_on    = q_data.mask_on;
          out_data_nxt.last       = !q_data.frame_end;
          if (q_data.frame_end) begin
            state_nxt = ctc_pkg::ST_CHECK;
          end
        end
      end
      ctc_pkg::ST_CHECK: begin
        zero_nxt  = (snap.total == '0);
        sat_x_nxt = (dvd_x >= lim);
        sat_y_nxt = (dvd_y >= lim);
        rem_x_nxt = WW'(dvd_x >> QW);
        rem_y_nxt = WW'(dvd_y >> QW);
        dlo_x_nxt = dvd_x[QW-1:0];
        dlo_y_nxt = dvd_y[QW-1:0];
        quo_x_nxt = '0;
        quo_y_nxt = '0;
        cnt_nxt   = CNT_W'(QW - 1);
        state_nxt = ctc_pkg::ST_DIV;
      end
      ctc_pkg::ST_DIV: begin
        rem_x_nxt = ge_x ? WW'(sh_x - dvs) : WW'(sh_x);
        rem_y_nxt = ge_y ? WW'(sh_y - dvs) : WW'(sh_y);
        dlo_x_nxt = dlo_x_r << 1;
        dlo_y_nxt = dlo_y_r << 1;
        quo_x_nxt = {quo_x_r[QW-2:0], ge_x};
        quo_y_nxt = {quo_y_r[QW-2:0], ge_y};
        if (cnt_r == '0) begin
          state_nxt = ctc_pkg::ST_LOAD;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ctc_pkg::ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = ctc_pkg::KIND_SUMMARY;
          out_data_nxt.mask_on    = 1'b0;
          out_data_nxt.pass_count = snap.passed;
          out_data_nxt.centroid_x = cent_x;
          out_data_nxt.centroid_y = cent_y;
          out_data_nxt.cog_valid  = !zero_r;
          out_data_nxt.last       = 1'b1;
          snap_done               = 1'b1;
          state_nxt               = ctc_pkg::ST_MASK;
        end
      end
      default: begin
        state_nxt = ctc_pkg::ST_MASK;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctc_pkg::ST_MASK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rem_x_r    <= rem_x_nxt;
    rem_y_r    <= rem_y_nxt;
    dlo_x_r    <= dlo_x_nxt;
    dlo_y_r    <= dlo_y_nxt;
    quo_x_r    <= quo_x_nxt;
    quo_y_r    <= quo_y_nxt;
    sat_x_r    <= sat_x_nxt;
    sat_y_r    <= sat_y_nxt;
    zero_r     <= zero_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Frame totals stay reserved for the whole summary computation
  a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ctc_pkg::ST_MASK) |-> snap_busy)
    else $error("summary computed without reserved frame totals");

  // A frame-end pixel always starts the centroid computation
  a_fe_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.frame_end) |=> (state_r == ctc_pkg::ST_CHECK))
    else $error("frame end did not start the division");

  // A summary is always the last result of its pixel and carries no mask
  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind == ctc_pkg::KIND_SUMMARY)) |->
      (out_data_r.last && !out_data_r.mask_on))
    else $error("malformed frame summary");

endmodule

`default_nettype wire

[sv/color_threshold_centroid_core.sv]
// Top level of the colour threshold and centroid core: register file, front
// end, queue and back end. Depends on ctc_pkg, ctc_cfg, ctc_front, ctc_queue, ctc_back.
//
//   Port group  Direction  Handshake                     Transaction
//   in_*        input      in_valid / in_stall           one RGB pixel with frame_end
//   out_*       output     out_valid / out_stall         mask result or frame summary
//   p*          APB        psel, penable, pready = 1     register write or read
//
// Pixels are taken one per clock while the four-entry queue has room.
// At a frame end the back end produces the summary after the last mask result
// through a check state, 19 divider steps and a load state that waits while the
// output is stalled; pixels keep entering until the queue fills, and a further
// frame-end pixel waits until the summary is out.
// Reset is synchronous, active low, and clears the position and sums.
// A stalled output holds its result; the output register breaks the data path, not the stall path.
`timescale 1ns / 1ps
`default_nettype none

module color_threshold_centroid_core #(
  parameter int unsigned MAX_WIDTH  = ctc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ctc_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = ctc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ctc_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ctc_pkg::out_item_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ctc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ctc_pkg::APB_DW-1:0]  pwdata,
  output logic      [ctc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  ctc_pkg::cfg_t  cfg_regs;
  ctc_pkg::qent_t q_push_data, q_pop_data;
  ctc_pkg::snap_t snap;
  logic           q_push, q_pop, q_full, q_empty;
  logic           snap_busy, snap_done;

  // Configuration registers
  ctc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_regs (cfg_regs)
  );

  // Classification and accumulation
  ctc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_regs  (cfg_regs),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .snap_done (snap_done),
    .snap_busy (snap_busy),
    .snap      (snap)
  );

  // Queue between front and back
  ctc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Result generation and centroid division
  ctc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .snap      (snap),
    .snap_busy (snap_busy),
    .snap_done (snap_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
